// ===== design/brfpd_pkg.sv =====
// Shared command codes, status codes and result type for the byte ring FIFO.
package brfpd_pkg;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;
    localparam logic [1:0] CMD_DROP = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    localparam logic [1:0] REG_ADDR_RING_LENGTH = 2'd0;
    localparam logic [8:0] RING_LENGTH_RESET    = 9'd256;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] count;
        logic       rd;
    } rslt_t;

endpackage

// ===== design/brfpd_mem.sv =====
// Byte storage of the ring with one write port and one registered read port.
module brfpd_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/brfpd_ctrl.sv =====
// Pointer, length and command logic of the byte ring FIFO with its result register.
module brfpd_ctrl
    import brfpd_pkg::*;
#(
    parameter int CAP    = 256,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_data,
    output logic [8:0]        ring_length,
    input  logic              start,
    input  logic [1:0]        command,
    input  logic [8:0]        amount,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    output logic              done,
    output rslt_t             rslt
);

    logic [8:0]        ring_length_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [ADDR_W-1:0] rp_reg;
    logic [ADDR_W-1:0] rp_next;
    logic              done_reg;
    rslt_t             rslt_reg;
    rslt_t             rslt_next;
    logic [8:0]        len;
    logic [8:0]        count;
    logic [8:0]        count_after;

    function automatic logic [8:0] wrap_add(input logic [8:0] base, input logic [8:0] delta,
                                            input logic [8:0] lim);
        logic [9:0] s;
        begin
            s = {1'b0, base} + {1'b0, delta};
            if (s >= {1'b0, lim})
            begin
                s = s - {1'b0, lim};
            end
            wrap_add = s[8:0];
        end
    endfunction

    function automatic logic [8:0] held(input logic [8:0] w, input logic [8:0] r,
                                        input logic [8:0] lim);
        begin
            if (w >= r)
            begin
                held = w - r;
            end
            else
            begin
                held = lim - (r - w);
            end
        end
    endfunction

    always_comb
    begin
        if (ring_length_reg < 9'd2)
        begin
            len = 9'd2;
        end
        else if (ring_length_reg > 9'(CAP))
        begin
            len = 9'(CAP);
        end
        else
        begin
            len = ring_length_reg;
        end
    end

    assign count = held(9'(wp_reg), 9'(rp_reg), len);

    always_comb
    begin
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = rp_reg;
        rslt_next.status = STAT_OK;
        rslt_next.rd     = 1'b0;
        case (command)
            CMD_PUSH:
            begin
                if (count >= len - 9'd1)
                begin
                    rslt_next.status = STAT_FULL;
                end
                else
                begin
                    mem_we  = start;
                    wp_next = ADDR_W'(wrap_add(9'(wp_reg), 9'd1, len));
                end
            end
            CMD_POP:
            begin
                if (count == 9'd0)
                begin
                    rslt_next.status = STAT_EMPTY;
                end
                else
                begin
                    mem_re       = start;
                    rslt_next.rd = 1'b1;
                    rp_next      = ADDR_W'(wrap_add(9'(rp_reg), 9'd1, len));
                end
            end
            CMD_PEEK:
            begin
                if (amount >= count)
                begin
                    rslt_next.status = STAT_BAD;
                end
                else
                begin
                    mem_re       = start;
                    rslt_next.rd = 1'b1;
                    mem_raddr    = ADDR_W'(wrap_add(9'(rp_reg), amount, len));
                end
            end
            CMD_DROP:
            begin
                if (amount == 9'd0 || amount > count)
                begin
                    rslt_next.status = STAT_BAD;
                end
                else
                begin
                    rp_next = ADDR_W'(wrap_add(9'(rp_reg), amount, len));
                end
            end
            default:
            begin
                rslt_next.status = STAT_BAD;
            end
        endcase
        count_after     = held(9'(wp_next), 9'(rp_next), len);
        rslt_next.count = count_after[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg <= RING_LENGTH_RESET;
            wp_reg          <= '0;
            rp_reg          <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (cfg_we)
            begin
                ring_length_reg <= cfg_data;
                wp_reg          <= '0;
                rp_reg          <= '0;
            end
            else if (start)
            begin
                wp_reg <= wp_next;
                rp_reg <= rp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rslt_reg <= rslt_next;
        end
    end

    assign mem_waddr   = wp_reg;
    assign ring_length = ring_length_reg;
    assign done        = done_reg;
    assign rslt        = rslt_reg;

endmodule

// ===== design/byte_ring_fifo_peek_drop_core.sv =====
// Top level of the byte ring FIFO with push, pop, peek and drop commands.
// The result of a command is strobed on done in the cycle after its transfer.
// Throughput: one command per cycle; busy is never raised and the receiver cannot stall.
// The byte storage has one write and one registered read port, at most one access per command.
// Reset clears both pointers and sets the ring length to 256; storage is not cleared.
module byte_ring_fifo_peek_drop_core
    import brfpd_pkg::*;
#(
    parameter int MAX_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic [8:0]  amount,
    output logic        done,
    output logic [7:0]  read_byte,
    output logic [1:0]  status,
    output logic [7:0]  stored_count
);

    localparam int CAP    = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam int ADDR_W = (CAP > 2) ? $clog2(CAP) : 1;

    logic              cfg_we;
    logic [8:0]        ring_length;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    rslt_t             rslt;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_ADDR_RING_LENGTH);
    assign prdata = (paddr == REG_ADDR_RING_LENGTH) ? {23'd0, ring_length} : 32'd0;

    brfpd_ctrl #(
        .CAP    (CAP),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (pwdata[8:0]),
        .ring_length (ring_length),
        .start       (start),
        .command     (command),
        .amount      (amount),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .done        (done),
        .rslt        (rslt)
    );

    brfpd_mem #(
        .DEPTH  (CAP),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign read_byte    = rslt.rd ? mem_rdata : 8'd0;
    assign status       = rslt.status;
    assign stored_count = rslt.count;

    // Every accepted command gives exactly one result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) start |=> done)
        else $error("command transfer without a result");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(start))
        else $error("result without a command transfer");

    // A failed command never returns a byte and pop on empty reports zero bytes held.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STAT_OK |-> read_byte == 8'd0)
        else $error("byte returned with an error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_EMPTY |-> stored_count == 8'd0)
        else $error("empty status with bytes held");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the byte ring FIFO core: directed table, then random command traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brfpd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int NUM_DIR_ROWS = 30;
    localparam int NUM_PHASES = 12;

    typedef struct packed {
        logic [7:0] rbyte;
        logic [1:0] stat;
        logic [7:0] cnt;
    } fifo_result_t;

    typedef struct {
        bit         is_cfg;
        logic [8:0] cfg_val;
        logic [1:0] cmd;
        logic [7:0] data;
        logic [8:0] amt;
        bit         typed;
        logic [7:0] rbyte;
        logic [1:0] stat;
        logic [7:0] cnt;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = REG_ADDR_RING_LENGTH;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = CMD_PUSH;
    logic [7:0]  data_byte = '0;
    logic [8:0]  amount = '0;
    logic        done;
    logic [7:0]  read_byte;
    logic [1:0]  status;
    logic [7:0]  stored_count;

    logic [7:0]   byte_mem [0:255];
    int unsigned  wr_ptr = 0;
    int unsigned  rd_ptr = 0;
    logic [8:0]   ring_len_reg = RING_LENGTH_RESET;

    fifo_result_t pending_results [$];
    int           mismatches = 0;
    int           cycle_count = 0;

    dir_row_t dir_rows [0:NUM_DIR_ROWS-1] = '{
        '{0, 9'd0,   CMD_POP,  8'h00, 9'd0,   1, 8'h00, STAT_EMPTY, 8'd0},
        '{0, 9'd0,   CMD_PEEK, 8'h00, 9'd0,   1, 8'h00, STAT_BAD,   8'd0},
        '{0, 9'd0,   CMD_DROP, 8'h00, 9'd0,   1, 8'h00, STAT_BAD,   8'd0},
        '{0, 9'd0,   CMD_PUSH, 8'hFF, 9'd0,   1, 8'h00, STAT_OK,    8'd1},
        '{0, 9'd0,   CMD_PUSH, 8'h00, 9'd511, 1, 8'h00, STAT_OK,    8'd2},
        '{0, 9'd0,   CMD_PUSH, 8'h5A, 9'd0,   1, 8'h00, STAT_OK,    8'd3},
        '{0, 9'd0,   CMD_PEEK, 8'h00, 9'd0,   1, 8'hFF, STAT_OK,    8'd3},
        '{0, 9'd0,   CMD_PEEK, 8'h00, 9'd2,   1, 8'h5A, STAT_OK,    8'd3},
        '{0, 9'd0,   CMD_PEEK, 8'h00, 9'd3,   1, 8'h00, STAT_BAD,   8'd3},
        '{0, 9'd0,   CMD_PEEK, 8'h00, 9'd256, 1, 8'h00, STAT_BAD,   8'd3},
        '{0, 9'd0,   CMD_DROP, 8'h00, 9'd4,   1, 8'h00, STAT_BAD,   8'd3},
        '{0, 9'd0,   CMD_POP,  8'h00, 9'd0,   1, 8'hFF, STAT_OK,    8'd2},
        '{0, 9'd0,   CMD_DROP, 8'h00, 9'd2,   1, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_PUSH, 8'hA5, 9'd256, 1, 8'h00, STAT_OK,    8'd1},
        '{1, 9'd2,   CMD_PUSH, 8'h00, 9'd0,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_PEEK, 8'h00, 9'd0,   1, 8'h00, STAT_BAD,   8'd0},
        '{0, 9'd0,   CMD_PUSH, 8'h81, 9'd0,   1, 8'h00, STAT_OK,    8'd1},
        '{0, 9'd0,   CMD_PUSH, 8'h7E, 9'd0,   1, 8'h00, STAT_FULL,  8'd1},
        '{0, 9'd0,   CMD_POP,  8'h00, 9'd0,   1, 8'h81, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_POP,  8'h00, 9'd0,   1, 8'h00, STAT_EMPTY, 8'd0},
        '{1, 9'd0,   CMD_PUSH, 8'h00, 9'd0,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_PUSH, 8'h3C, 9'd0,   1, 8'h00, STAT_OK,    8'd1},
        '{0, 9'd0,   CMD_PUSH, 8'hC3, 9'd0,   1, 8'h00, STAT_FULL,  8'd1},
        '{1, 9'd3,   CMD_PUSH, 8'h00, 9'd0,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_PUSH, 8'h11, 9'd0,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_PUSH, 8'h22, 9'd0,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_POP,  8'h00, 9'd0,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_PUSH, 8'h33, 9'd0,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_PEEK, 8'h00, 9'd1,   0, 8'h00, STAT_OK,    8'd0},
        '{0, 9'd0,   CMD_DROP, 8'h00, 9'd2,   0, 8'h00, STAT_OK,    8'd0}
    };

    int unsigned phase_len [0:NUM_PHASES-1] = '{2, 3, 256, 0, 5, 511, 17, 1, 255, 4, 2, 9};

    byte_ring_fifo_peek_drop_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .data_byte    (data_byte),
        .amount       (amount),
        .done         (done),
        .read_byte    (read_byte),
        .status       (status),
        .stored_count (stored_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned live_length();
        int unsigned l;
        l = 32'(ring_len_reg);
        if (l < 2)
            l = 2;
        if (l > 256)
            l = 256;
        return l;
    endfunction

    function automatic int unsigned fill_level();
        if (wr_ptr >= rd_ptr)
            return wr_ptr - rd_ptr;
        return live_length() - (rd_ptr - wr_ptr);
    endfunction

    function automatic void predict_fifo_cmd(input logic [1:0] cmd, input logic [7:0] data,
                                             input logic [8:0] amt, output fifo_result_t r);
        int unsigned len;
        int unsigned lvl;
        len = live_length();
        lvl = fill_level();
        r.rbyte = 8'h00;
        r.stat = STAT_OK;
        case (cmd)
            CMD_PUSH:
            begin
                if (lvl >= len - 1)
                    r.stat = STAT_FULL;
                else
                begin
                    byte_mem[wr_ptr] = data;
                    wr_ptr = (wr_ptr + 1) % len;
                end
            end
            CMD_POP:
            begin
                if (lvl == 0)
                    r.stat = STAT_EMPTY;
                else
                begin
                    r.rbyte = byte_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % len;
                end
            end
            CMD_PEEK:
            begin
                if (amt >= lvl)
                    r.stat = STAT_BAD;
                else
                    r.rbyte = byte_mem[(rd_ptr + amt) % len];
            end
            default:
            begin
                if (amt == 0 || amt > lvl)
                    r.stat = STAT_BAD;
                else
                    rd_ptr = (rd_ptr + amt) % len;
            end
        endcase
        r.cnt = 8'(fill_level());
    endfunction

    function automatic int pick_gap(input bit quiet);
        int g;
        g = 0;
        while (!quiet && $urandom_range(0, 99) < 22)
            g++;
        return g;
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data, input logic [8:0] amt,
                            input bit typed, input fifo_result_t typed_res, input int gap,
                            input bit hold);
        fifo_result_t r;
        if (gap > 0 || hold)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if (hold)
            begin
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
        end
        start <= 1'b1;
        command <= cmd;
        data_byte <= data;
        amount <= amt;
        do
            @(posedge clk);
        while (busy);
        predict_fifo_cmd(cmd, data, amt, r);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic quiesce();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_ring_length(input logic [8:0] val);
        quiesce();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_ADDR_RING_LENGTH;
        pwdata <= {23'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        ring_len_reg = val;
        wr_ptr = 0;
        rd_ptr = 0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {23'd0, val})
        begin
            $error("ring_length: expected %0h, actual %0h", {23'd0, val}, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        fifo_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobed with no transfer pending");
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (read_byte !== exp_r.rbyte)
                begin
                    $error("read_byte: expected %0h, actual %0h", exp_r.rbyte, read_byte);
                    mismatches++;
                end
                if (status !== exp_r.stat)
                begin
                    $error("status: expected %0h, actual %0h", exp_r.stat, status);
                    mismatches++;
                end
                if (stored_count !== exp_r.cnt)
                begin
                    $error("stored_count: expected %0h, actual %0h", exp_r.cnt, stored_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned  n_items;
        int unsigned  lvl;
        int           mode;
        int           mode_left;
        int           r1;
        int           r2;
        bit           quiet;
        logic [8:0]   len_val;
        logic [1:0]   cmd;
        logic [8:0]   amt;
        fifo_result_t typed_res;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR_ROWS; i++)
        begin
            if (dir_rows[i].is_cfg)
                write_ring_length(dir_rows[i].cfg_val);
            else
            begin
                typed_res = '{dir_rows[i].rbyte, dir_rows[i].stat, dir_rows[i].cnt};
                send_cmd(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].amt,
                         dir_rows[i].typed, typed_res, pick_gap(1'b0), 1'b0);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            len_val = (p == 10) ? 9'($urandom_range(2, 40)) : 9'(phase_len[p]);
            write_ring_length(len_val);
            n_items = (live_length() > 64) ? 330 : 73;
            quiet = (p == 2);
            mode_left = 0;
            mode = 2;
            for (int k = 0; k < n_items; k++)
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 256);
                end
                mode_left--;
                lvl = fill_level();
                r1 = $urandom_range(0, 99);
                r2 = $urandom_range(0, 99);
                if (mode == 0)
                    cmd = (r1 < 90) ? CMD_PUSH : 2'($urandom_range(1, 3));
                else if (mode == 1)
                    cmd = (r1 < 45) ? CMD_POP : (r1 < 75) ? CMD_DROP :
                          (r1 < 90) ? CMD_PEEK : CMD_PUSH;
                else
                    cmd = 2'($urandom_range(0, 3));
                if (cmd == CMD_DROP)
                begin
                    if (r2 < 70)
                        amt = (lvl == 0) ? 9'd0 : 9'($urandom_range(1, lvl));
                    else if (r2 < 85)
                        amt = 9'(lvl + 1);
                    else
                        amt = 9'($urandom_range(0, 256));
                end
                else if (cmd == CMD_PEEK && r2 < 80)
                    amt = 9'($urandom_range(0, lvl));
                else
                    amt = 9'($urandom_range(0, 256));
                send_cmd(cmd, 8'($urandom_range(0, 255)), amt, 1'b0, '0, pick_gap(quiet),
                         k == n_items / 2);
            end
        end

        quiesce();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/brfpd_pkg.sv
design/brfpd_mem.sv
design/brfpd_ctrl.sv
design/byte_ring_fifo_peek_drop_core.sv
dv/tb_top.sv
